[src/gprb_pkg.sv]
package gprb_pkg;

	// configuration word value after reset, mode 4 in every nibble
	localparam logic [31:0] MODE_RESET = 32'h4444_4444;

	// bit of the lock register that carries the key
	localparam int KEY_BIT = 16;

	// pins that the register map has room for
	localparam int MAX_PINS = 16;

	// access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// word register map
	typedef enum logic [2:0] {
		REG_CFG_LOW  = 3'd0,
		REG_CFG_HIGH = 3'd1,
		REG_INPUT    = 3'd2,
		REG_OUTPUT   = 3'd3,
		REG_SET_RST  = 3'd4,
		REG_RESET    = 3'd5,
		REG_LOCK     = 3'd6,
		REG_NONE     = 3'd7
	} reg_sel_t;

	// lock key sequence
	typedef enum logic [1:0] {
		LOCK_IDLE  = 2'd0,
		LOCK_KEY1  = 2'd1,
		LOCK_KEY0  = 2'd2,
		LOCK_ARMED = 2'd3
	} lock_step_t;

	// one register access request
	typedef struct packed {
		logic                  wr;
		reg_sel_t              sel;
		logic [31:0]           data;
		logic [MAX_PINS-1:0]   levels;
	} access_t;

	// lock status seen by the port registers
	typedef struct packed {
		logic                  key;
		logic [MAX_PINS-1:0]   mask;
	} lock_status_t;

	// mask of the pins that are implemented
	function automatic logic [MAX_PINS-1:0] pins_present(input int count);
		logic [MAX_PINS-1:0] m;
		for (int i = 0; i < MAX_PINS; i++) begin
			m[i] = (i < count);
		end
		return m;
	endfunction

endpackage

[src/gprb_lock.sv]
module gprb_lock #(
	parameter int PIN_COUNT = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  gprb_pkg::access_t      acc,
	output gprb_pkg::lock_status_t status,
	output gprb_pkg::lock_status_t status_d,
	output logic [31:0]            lock_word
);
	import gprb_pkg::*;

	localparam logic [MAX_PINS-1:0] PRESENT = pins_present(PIN_COUNT);

	lock_step_t          step_q, step_d;
	logic                key_q, key_d;
	logic [MAX_PINS-1:0] mask_q, mask_d;
	logic [MAX_PINS-1:0] wr_mask;
	logic                wr_key;
	logic                same;
	logic                lock_wr;
	logic                lock_rd;

	// decode of the lock register request
	assign wr_mask = acc.data[MAX_PINS-1:0] & PRESENT;
	assign wr_key  = acc.data[KEY_BIT];
	assign same    = (wr_mask == mask_q);
	assign lock_wr = en && (acc.wr == FUNC_WRITE) && (acc.sel == REG_LOCK) && !key_q;
	assign lock_rd = en && (acc.wr == FUNC_READ) && (acc.sel == REG_LOCK);

	// key sequence next state
	always_comb begin
		step_d = step_q;
		if (lock_wr) begin
			unique case (step_q)
				LOCK_KEY1: begin
					step_d = (!wr_key && same) ? LOCK_KEY0 : (wr_key ? LOCK_KEY1 : LOCK_IDLE);
				end
				LOCK_KEY0: begin
					step_d = (wr_key && same) ? LOCK_ARMED : LOCK_KEY1;
					if (!wr_key) begin
						step_d = LOCK_IDLE;
					end
				end
				default: begin
					step_d = wr_key ? LOCK_KEY1 : LOCK_IDLE;
				end
			endcase
		end else if (lock_rd && !key_q && step_q == LOCK_ARMED) begin
			step_d = LOCK_IDLE;
		end
	end

	// key, mask and read word
	always_comb begin
		key_d     = key_q | (lock_rd && step_q == LOCK_ARMED);
		mask_d    = lock_wr ? wr_mask : mask_q;
		lock_word = {{(31 - KEY_BIT){1'b0}}, key_q, mask_q};
	end

	// lock state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= LOCK_IDLE;
			key_q  <= 1'b0;
			mask_q <= '0;
		end else begin
			step_q <= step_d;
			key_q  <= key_d;
			mask_q <= mask_d;
		end
	end

	assign status   = '{key: key_q, mask: mask_q};
	assign status_d = '{key: key_d, mask: mask_d};

	// once locked, only reset unlocks
	a_key_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		key_q |=> key_q)
		else $error("lock key dropped without reset");

	// the mask is frozen while locked
	a_mask_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		key_q |=> $stable(mask_q))
		else $error("lock mask changed while locked");

	// no sequence runs once locked
	a_idle_locked: assert property (@(posedge clk) disable iff (!arst_n)
		key_q |-> step_q == LOCK_IDLE)
		else $error("key sequence active while locked");

endmodule

[src/gprb_port.sv]
module gprb_port #(
	parameter int PIN_COUNT = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  gprb_pkg::access_t      acc,
	input  gprb_pkg::lock_status_t lock,
	output logic [31:0]            mode_low_d,
	output logic [31:0]            mode_high_d,
	output logic [15:0]            drive_d,
	output logic [31:0]            port_word
);
	import gprb_pkg::*;

	localparam logic [MAX_PINS-1:0] PRESENT = pins_present(PIN_COUNT);

	logic [31:0]         mode_low_q, mode_high_q;
	logic [MAX_PINS-1:0] out_bits_q;
	logic [MAX_PINS-1:0] keep_pin;
	logic [63:0]         keep_nib;

	// nibbles that ignore writes: absent pins and locked pins
	always_comb begin
		for (int i = 0; i < MAX_PINS; i++) begin
			keep_pin[i]          = !PRESENT[i] || (lock.key && lock.mask[i]);
			keep_nib[i*4 +: 4]   = {4{keep_pin[i]}};
		end
	end

	// register writes
	always_comb begin
		mode_low_d  = mode_low_q;
		mode_high_d = mode_high_q;
		drive_d     = out_bits_q;
		if (en && acc.wr == FUNC_WRITE) begin
			unique case (acc.sel)
				REG_CFG_LOW: begin
					mode_low_d = (mode_low_q & keep_nib[31:0]) | (acc.data & ~keep_nib[31:0]);
				end
				REG_CFG_HIGH: begin
					mode_high_d = (mode_high_q & keep_nib[63:32])
						| (acc.data & ~keep_nib[63:32]);
				end
				REG_OUTPUT: begin
					drive_d = acc.data[15:0] & PRESENT;
				end
				REG_SET_RST: begin
					drive_d = ((out_bits_q & ~acc.data[31:16]) | acc.data[15:0]) & PRESENT;
				end
				REG_RESET: begin
					drive_d = out_bits_q & ~acc.data[15:0] & PRESENT;
				end
				default: begin
				end
			endcase
		end
	end

	// register reads, from the state before the request
	always_comb begin
		port_word = '0;
		if (acc.wr == FUNC_READ) begin
			unique case (acc.sel)
				REG_CFG_LOW:  port_word = mode_low_q;
				REG_CFG_HIGH: port_word = mode_high_q;
				REG_INPUT:    port_word = {16'd0, acc.levels & PRESENT};
				REG_OUTPUT:   port_word = {16'd0, out_bits_q};
				default:      port_word = '0;
			endcase
		end
	end

	// port registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_low_q  <= MODE_RESET;
			mode_high_q <= MODE_RESET;
			out_bits_q  <= '0;
		end else begin
			mode_low_q  <= mode_low_d;
			mode_high_q <= mode_high_d;
			out_bits_q  <= drive_d;
		end
	end

	// absent pins never drive
	a_absent_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_bits_q & ~PRESENT) == '0)
		else $error("output bit set on an absent pin");

endmodule

[src/gpio_port_register_block.sv]
// Register file of a 16-pin GPIO port with a configuration lock. Each request
// is one word read or write; one result comes back per request, carrying the
// read data (zero on writes) and the pin drive, pin modes and lock state as
// they stand after the request. A request is taken every cycle while the result
// side does not stall; a result goes through the input register, then the result
// register, and the input side keeps taking requests while a result waits, as
// long as the result register frees up in the same cycle.
module gpio_port_register_block #(
	parameter int PIN_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [2:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic [15:0] pin_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [15:0] pin_drive,
	output logic [63:0] pin_modes,
	output logic        lock_active
);
	import gprb_pkg::*;

	logic         valid_s1;
	access_t      acc_s1;
	logic         adv;
	logic         out_valid_s2;
	logic [31:0]  read_data_s2;
	logic [15:0]  pin_drive_s2;
	logic [63:0]  pin_modes_s2;
	logic         lock_active_s2;
	lock_status_t lock_status;
	lock_status_t lock_status_d;
	logic [31:0]  lock_word;
	logic [31:0]  port_word;
	logic [31:0]  mode_low_d, mode_high_d;
	logic [15:0]  drive_d;
	logic [31:0]  rd;

	// handshake
	assign adv      = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			acc_s1 <= '{wr: func, sel: reg_sel_t'(reg_index), data: write_data,
				levels: pin_levels};
		end
	end

	gprb_lock #(
		.PIN_COUNT(PIN_COUNT)
	) u_lock (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.acc      (acc_s1),
		.status   (lock_status),
		.status_d (lock_status_d),
		.lock_word(lock_word)
	);

	gprb_port #(
		.PIN_COUNT(PIN_COUNT)
	) u_port (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.acc        (acc_s1),
		.lock       (lock_status),
		.mode_low_d (mode_low_d),
		.mode_high_d(mode_high_d),
		.drive_d    (drive_d),
		.port_word  (port_word)
	);

	// read data merge
	assign rd = port_word
		| (((acc_s1.wr == FUNC_READ) && (acc_s1.sel == REG_LOCK)) ? lock_word : 32'd0);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_s2   <= rd;
			pin_drive_s2   <= drive_d;
			pin_modes_s2   <= {mode_high_d, mode_low_d};
			lock_active_s2 <= lock_status_d.key;
		end
	end

	assign out_valid   = out_valid_s2;
	assign read_data   = read_data_s2;
	assign pin_drive   = pin_drive_s2;
	assign pin_modes   = pin_modes_s2;
	assign lock_active = lock_active_s2;

endmodule

[tb/sv/gpio_port_register_block_tb.sv]
`timescale 1ns / 1ps

module gpio_port_register_block_tb;
	import gprb_pkg::*;

	localparam int PINS = 16;
	localparam int DIR_ROWS = 25;
	localparam int WATCHDOG = 2000;
	localparam logic [15:0] PRESENT = (PINS >= MAX_PINS) ? '1 : 16'((1 << PINS) - 1);
	localparam logic [63:0] MODES_RST = {MODE_RESET, MODE_RESET};

	// what the port shows after one request
	typedef struct packed {
		logic [31:0] rd;
		logic [15:0] drive;
		logic [63:0] modes;
		logic        act;
	} port_view_t;

	// directed request; known rows carry their read data and drive, and all of them
	// come before any mode change or lock, so modes and lock stay at reset there
	typedef struct packed {
		logic        wr;
		reg_sel_t    sel;
		logic [31:0] data;
		logic [15:0] levels;
		logic        known;
		logic [31:0] rd;
		logic [15:0] drive;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{FUNC_READ,  REG_CFG_LOW,  32'h0000_0000, 16'h0000, 1'b1, 32'h4444_4444, 16'h0000},
		'{FUNC_READ,  REG_CFG_HIGH, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h4444_4444, 16'h0000},
		'{FUNC_READ,  REG_INPUT,    32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_FFFF, 16'h0000},
		'{FUNC_READ,  REG_INPUT,    32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0000_0000, 16'h0000},
		'{FUNC_WRITE, REG_OUTPUT,   32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0000_0000, 16'hFFFF},
		'{FUNC_READ,  REG_OUTPUT,   32'h0000_0000, 16'h1234, 1'b1, 32'h0000_FFFF, 16'hFFFF},
		'{FUNC_WRITE, REG_SET_RST,  32'hFFFF_0000, 16'h0000, 1'b1, 32'h0000_0000, 16'h0000},
		'{FUNC_WRITE, REG_SET_RST,  32'hFFFF_00FF, 16'h0000, 1'b1, 32'h0000_0000, 16'h00FF},
		'{FUNC_WRITE, REG_RESET,    32'hFFFF_000F, 16'h0000, 1'b1, 32'h0000_0000, 16'h00F0},
		'{FUNC_READ,  REG_SET_RST,  32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000, 16'h00F0},
		'{FUNC_READ,  REG_RESET,    32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000, 16'h00F0},
		'{FUNC_READ,  REG_NONE,     32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000, 16'h00F0},
		'{FUNC_WRITE, REG_INPUT,    32'h1234_5678, 16'hFFFF, 1'b1, 32'h0000_0000, 16'h00F0},
		'{FUNC_WRITE, REG_NONE,     32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0000_0000, 16'h00F0},
		'{FUNC_WRITE, REG_CFG_LOW,  32'hFFFF_FFFF, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_CFG_HIGH, 32'h0000_0000, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_LOCK,     32'h0001_00FF, 16'h0000, 1'b0, '0, '0},
		'{FUNC_READ,  REG_LOCK,     32'h0000_0000, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_LOCK,     32'h0000_00FF, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_LOCK,     32'h0001_0F0F, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_LOCK,     32'h0000_0F0F, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_OUTPUT,   32'h0000_ABCD, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_LOCK,     32'hFFFF_0F0F, 16'h0000, 1'b0, '0, '0},
		'{FUNC_WRITE, REG_LOCK,     32'h0000_0F0F, 16'h0000, 1'b0, '0, '0},
		'{FUNC_READ,  REG_LOCK,     32'h0000_0000, 16'h0000, 1'b0, '0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [2:0]  reg_index;
	logic [31:0] write_data;
	logic [15:0] pin_levels;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic [15:0] pin_drive;
	logic [63:0] pin_modes;
	logic        lock_active;

	// predicted port state
	logic [31:0] mode_lo;
	logic [31:0] mode_hi;
	logic [15:0] out_bits;
	logic [15:0] lk_mask;
	logic        lk_key;
	lock_step_t  lk_step;
	logic [15:0] seq_mask;

	port_view_t  port_views_due [$];
	port_view_t  typed_res;
	bit          typed_row;
	bit          in_take;
	bit          out_take;
	bit          burst;
	int          bad_fields;
	int          quiet_cycles;

	gpio_port_register_block #(
		.PIN_COUNT(PINS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.reg_index(reg_index),
		.write_data(write_data),
		.pin_levels(pin_levels),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.pin_drive(pin_drive),
		.pin_modes(pin_modes),
		.lock_active(lock_active)
	);

	always #4 clk = ~clk;

	// config word write, nibbles of locked pins hold
	function automatic logic [31:0] merge_nibbles(input logic [31:0] old,
			input logic [31:0] data, input int base);
		logic [31:0] hold;
		hold = '0;
		for (int p = 0; p < 8; p++) begin
			if (base + p >= PINS || (lk_key && lk_mask[base + p]))
				hold[p*4 +: 4] = 4'hF;
		end
		return (old & hold) | (data & ~hold);
	endfunction

	// apply one request to the predicted state and return what the port shows
	function automatic port_view_t gpio_predict(input access_t a);
		port_view_t v;
		logic [31:0] rd;
		logic [15:0] m;
		logic k;
		rd = '0;
		m = a.data[15:0] & PRESENT;
		k = a.data[KEY_BIT];
		if (a.wr == FUNC_WRITE) begin
			case (a.sel)
				REG_CFG_LOW:  mode_lo = merge_nibbles(mode_lo, a.data, 0);
				REG_CFG_HIGH: mode_hi = merge_nibbles(mode_hi, a.data, 8);
				REG_OUTPUT:   out_bits = a.data[15:0] & PRESENT;
				REG_SET_RST:  out_bits = ((out_bits & ~a.data[31:16]) | a.data[15:0]) & PRESENT;
				REG_RESET:    out_bits = out_bits & ~a.data[15:0] & PRESENT;
				REG_LOCK: begin
					if (!lk_key) begin
						if (lk_step == LOCK_KEY1 && !k && m == lk_mask)
							lk_step = LOCK_KEY0;
						else if (lk_step == LOCK_KEY0 && k && m == lk_mask)
							lk_step = LOCK_ARMED;
						else
							lk_step = k ? LOCK_KEY1 : LOCK_IDLE;
						lk_mask = m;
					end
				end
				default: ;
			endcase
		end else begin
			case (a.sel)
				REG_CFG_LOW:  rd = mode_lo;
				REG_CFG_HIGH: rd = mode_hi;
				REG_INPUT:    rd = {16'h0, a.levels & PRESENT};
				REG_OUTPUT:   rd = {16'h0, out_bits};
				REG_LOCK: begin
					rd = {15'h0, lk_key, lk_mask};
					// the read after a full key sequence sets the lock
					if (!lk_key && lk_step == LOCK_ARMED) begin
						lk_key = 1'b1;
						lk_step = LOCK_IDLE;
					end
				end
				default: ;
			endcase
		end
		v.rd = rd;
		v.drive = out_bits;
		v.modes = {mode_hi, mode_lo};
		v.act = lk_key;
		return v;
	endfunction

	function automatic int pause_len();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// random request; while unlocked, three in ten walk the lock key sequence with random masks,
	// sometimes breaking it; the lock read that would close it only when allowed
	function automatic access_t pick_access(input bit close_lock);
		access_t a;
		int r;
		r = $urandom_range(0, 99);
		a.wr = 1'($urandom_range(0, 1));
		a.sel = reg_sel_t'($urandom_range(0, 7));
		a.data = rand_word();
		a.levels = 16'($urandom);
		if (r < 30 && !lk_key) begin
			a.wr = FUNC_WRITE;
			a.sel = REG_LOCK;
			a.data = $urandom;
			case (lk_step)
				LOCK_IDLE: begin
					seq_mask = 16'($urandom);
					a.data[KEY_BIT] = 1'b1;
				end
				LOCK_KEY1: a.data[KEY_BIT] = 1'b0;
				LOCK_KEY0: a.data[KEY_BIT] = 1'b1;
				default: if (close_lock) a.wr = FUNC_READ;
			endcase
			a.data[15:0] = seq_mask;
			if ($urandom_range(0, 6) == 0)
				a.data[$urandom_range(0, KEY_BIT)] ^= 1'b1;
		end else if (r < 30) begin
			// locked: hammer the config words and the lock register
			a.wr = FUNC_WRITE;
			if (r < 20)
				a.sel = (r < 10) ? REG_CFG_LOW : REG_CFG_HIGH;
			else
				a.sel = REG_LOCK;
		end
		if (!close_lock && lk_step == LOCK_ARMED && a.wr == FUNC_READ && a.sel == REG_LOCK)
			a.sel = REG_OUTPUT;
		return a;
	endfunction

	// drive one request and hold it until accepted
	task automatic issue(input access_t a, input bit typed, input port_view_t tv);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_row = typed;
		typed_res = tv;
		in_valid <= 1'b1;
		func <= a.wr;
		reg_index <= a.sel;
		write_data <= a.data;
		pin_levels <= a.levels;
		do @(posedge clk); while (!in_take);
		if ($urandom_range(0, 79) == 0)
			burst = ~burst;
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			bad_fields++;
			if (bad_fields <= 50)
				$display("%0t %s expected %h actual %h", $time, what, want, got);
		end
	endtask

	// sample handshakes on the falling edge, between drive edges
	always @(negedge clk) begin
		access_t cur;
		port_view_t want;
		in_take = in_valid && in_ready;
		out_take = out_valid && out_ready;
		if (in_take) begin
			cur.wr = func;
			cur.sel = reg_sel_t'(reg_index);
			cur.data = write_data;
			cur.levels = pin_levels;
			want = gpio_predict(cur);
			port_views_due.push_back(typed_row ? typed_res : want);
		end
		if (out_take) begin
			if (port_views_due.size() == 0) begin
				bad_fields++;
				$display("%0t result with no request pending", $time);
			end else begin
				want = port_views_due.pop_front();
				check_field("read_data", 64'(want.rd), 64'(read_data));
				check_field("pin_drive", 64'(want.drive), 64'(pin_drive));
				check_field("pin_modes", want.modes, pin_modes);
				check_field("lock_active", 64'(want.act), 64'(lock_active));
			end
		end
		// watchdog on handshake progress
		if (in_take || out_take) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_take)
				hold = pause_len();
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// request side
	initial begin
		access_t a;
		dir_row_t row;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_READ;
		reg_index = REG_NONE;
		write_data = '0;
		pin_levels = '0;
		typed_row = 1'b0;
		typed_res = '0;
		burst = 1'b0;
		bad_fields = 0;
		quiet_cycles = 0;
		mode_lo = MODE_RESET;
		mode_hi = MODE_RESET;
		out_bits = '0;
		lk_mask = '0;
		lk_key = 1'b0;
		lk_step = LOCK_IDLE;
		seq_mask = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			a.wr = row.wr;
			a.sel = row.sel;
			a.data = row.data;
			a.levels = row.levels;
			issue(a, row.known, '{row.rd, row.drive, MODES_RST, 1'b0});
		end

		// random traffic with the lock kept open
		repeat (1050) issue(pick_access(1'b0), 1'b0, '0);

		// let every result come back before the lock closes
		in_valid <= 1'b0;
		@(posedge clk);
		while (port_views_due.size() != 0) @(posedge clk);

		// close the lock, then run locked
		n = 0;
		while (n < 275) begin
			issue(pick_access(1'b1), 1'b0, '0);
			if (lk_key)
				n++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (port_views_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (bad_fields == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
